### hdl/gerc_pkg.sv
package gerc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int LVL_W      = FRAC_BITS + 1;
  localparam int MRG_W      = FRAC_BITS - 1;
  localparam int U_W        = FRAC_BITS + 3;
  localparam int STG_STEPS  = 2;
  localparam int DIV_STAGES = (FRAC_BITS + 4 + STG_STEPS - 1) / STG_STEPS;
  localparam int Q_W        = DIV_STAGES * STG_STEPS;
  localparam int IN_SH      = Q_W - FRAC_BITS;

  localparam logic [LVL_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_GREY,
    MODE_RAIN
  } mode_t;

  typedef struct packed {
    mode_t            mode;
    logic [LVL_W-1:0] rem;
    logic [LVL_W-1:0] den;
    logic [Q_W-1:0]   num;
    logic [Q_W-1:0]   q;
  } div_t;

endpackage

### hdl/grey_ended_rainbow_colormap.sv
// Port group   Handshake             Payload
// in_          in_valid / in_stall   in_level [16:0]
// out_         out_valid / out_stall out_red, out_green, out_blue [16:0]
// cfg_         cfg_we                cfg_wdata [14:0] (grey margin)
//
// One item per clock unless out_stall holds it back; the pipeline has two front
// stages, ten divider stages of two quotient bits each and one output register.
// Synchronous active-low reset clears all valid bits and the margin to zero.
// Each stage advances when it is empty or the next stage takes its item, so
// bubbles collapse under out_stall and nothing is lost or repeated.
module grey_ended_rainbow_colormap
  import gerc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [LVL_W-1:0] in_level,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [LVL_W-1:0] out_red,
  output logic [LVL_W-1:0] out_green,
  output logic [LVL_W-1:0] out_blue,
  input  logic             cfg_we,
  input  logic [MRG_W-1:0] cfg_wdata
);

  logic [MRG_W-1:0] margin_r;
  logic             v     [DIV_STAGES+1];
  div_t             d     [DIV_STAGES+1];
  logic             rdy   [DIV_STAGES+1];
  logic             front_ready;

  assign in_stall = !front_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= '0;
    end else if (cfg_we) begin
      margin_r <= cfg_wdata;
    end
  end

  gerc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .level      (in_level),
    .margin     (margin_r),
    .up_ready   (front_ready),
    .down_ready (rdy[0]),
    .v_out      (v[0]),
    .d_out      (d[0])
  );

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    gerc_div_stage u_stage (
      .clk        (clk),
      .rst_n      (rst_n),
      .v_in       (v[i]),
      .d_in       (d[i]),
      .up_ready   (rdy[i]),
      .down_ready (rdy[i+1]),
      .v_out      (v[i+1]),
      .d_out      (d[i+1])
    );
  end

  gerc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .v_in      (v[DIV_STAGES]),
    .d_in      (d[DIV_STAGES]),
    .up_ready  (rdy[DIV_STAGES]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

endmodule

### hdl/gerc_front.sv
module gerc_front
  import gerc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [LVL_W-1:0] level,
  input  logic [MRG_W-1:0] margin,
  output logic             up_ready,
  input  logic             down_ready,
  output logic             v_out,
  output div_t             d_out
);

  logic             v1_r, v2_r;
  mode_t            mode1_r, mode1_nxt;
  logic [LVL_W-1:0] diff1_r, diff1_nxt;
  logic [LVL_W-1:0] den1_r, den1_nxt;
  div_t             d2_r, d2_nxt;
  logic             ready1, ready2;
  logic [LVL_W-1:0] g;
  logic [U_W-1:0]   u;

  assign ready2   = !v2_r || down_ready;
  assign ready1   = !v1_r || ready2;
  assign up_ready = ready1;
  assign v_out    = v2_r;
  assign d_out    = d2_r;

  assign g = LVL_W'(margin);

  // classify the level and pick dividend and divisor
  always_comb begin
    mode1_nxt = MODE_ZERO;
    diff1_nxt = '0;
    den1_nxt  = g;
    priority if (level > ONE) begin
      mode1_nxt = MODE_ZERO;
    end else if (level < g) begin
      mode1_nxt = MODE_GREY;
      diff1_nxt = g - level;
    end else if (level >= ONE - g) begin
      mode1_nxt = (g == '0) ? MODE_ZERO : MODE_GREY;
      diff1_nxt = ONE - level;
    end else begin
      mode1_nxt = MODE_RAIN;
      diff1_nxt = level - g;
      den1_nxt  = ONE - (g << 1);
    end
  end

  // scale by seven in the rainbow span and seed the divider
  always_comb begin
    if (mode1_r == MODE_RAIN) begin
      u = (U_W'(diff1_r) << 3) - U_W'(diff1_r);
    end else begin
      u = U_W'(diff1_r);
    end
    d2_nxt.mode = mode1_r;
    d2_nxt.den  = den1_r;
    d2_nxt.rem  = LVL_W'(u >> IN_SH);
    d2_nxt.num  = {u[IN_SH-1:0], {FRAC_BITS{1'b0}}};
    d2_nxt.q    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (ready1) begin
        v1_r <= in_valid;
      end
      if (ready2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      mode1_r <= mode1_nxt;
      diff1_r <= diff1_nxt;
      den1_r  <= den1_nxt;
    end
    if (ready2) begin
      d2_r <= d2_nxt;
    end
  end

endmodule

### hdl/gerc_div_stage.sv
module gerc_div_stage
  import gerc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic v_in,
  input  div_t d_in,
  output logic up_ready,
  input  logic down_ready,
  output logic v_out,
  output div_t d_out
);

  logic             v_r;
  div_t             d_r, d_nxt;
  logic [LVL_W:0]   rs;

  assign up_ready = !v_r || down_ready;
  assign v_out    = v_r;
  assign d_out    = d_r;

  // restoring division, one quotient bit per step
  always_comb begin
    d_nxt = d_in;
    rs    = '0;
    for (int i = 0; i < STG_STEPS; i++) begin
      rs = {d_nxt.rem, d_nxt.num[Q_W-1]};
      d_nxt.num = d_nxt.num << 1;
      if (rs >= {1'b0, d_nxt.den}) begin
        d_nxt.rem = LVL_W'(rs - {1'b0, d_nxt.den});
        d_nxt.q   = {d_nxt.q[Q_W-2:0], 1'b1};
      end else begin
        d_nxt.rem = LVL_W'(rs);
        d_nxt.q   = {d_nxt.q[Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      d_r <= d_nxt;
    end
  end

endmodule

### hdl/gerc_back.sv
module gerc_back
  import gerc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             v_in,
  input  div_t             d_in,
  output logic             up_ready,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [LVL_W-1:0] out_red,
  output logic [LVL_W-1:0] out_green,
  output logic [LVL_W-1:0] out_blue
);

  logic             v_r;
  logic [LVL_W-1:0] red_r, red_nxt;
  logic [LVL_W-1:0] green_r, green_nxt;
  logic [LVL_W-1:0] blue_r, blue_nxt;
  logic [2:0]       seg;
  logic [LVL_W-1:0] up, dn;

  assign up_ready  = !v_r || !out_stall;
  assign out_valid = v_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  assign seg = d_in.q[FRAC_BITS+2:FRAC_BITS];
  assign up  = {1'b0, d_in.q[FRAC_BITS-1:0]};
  assign dn  = ONE - up - LVL_W'(d_in.rem != '0);

  always_comb begin
    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    unique case (d_in.mode)
      MODE_GREY: begin
        red_nxt   = d_in.q[FRAC_BITS:0];
        green_nxt = d_in.q[FRAC_BITS:0];
        blue_nxt  = d_in.q[FRAC_BITS:0];
      end
      MODE_RAIN: begin
        unique case (seg)
          3'd0: begin red_nxt = up;  green_nxt = '0;  blue_nxt = up;  end
          3'd1: begin red_nxt = dn;  green_nxt = '0;  blue_nxt = ONE; end
          3'd2: begin red_nxt = '0;  green_nxt = up;  blue_nxt = ONE; end
          3'd3: begin red_nxt = '0;  green_nxt = ONE; blue_nxt = dn;  end
          3'd4: begin red_nxt = up;  green_nxt = ONE; blue_nxt = '0;  end
          3'd5: begin red_nxt = ONE; green_nxt = dn;  blue_nxt = '0;  end
          default: begin red_nxt = ONE; green_nxt = up; blue_nxt = up; end
        endcase
      end
      default: begin
        red_nxt   = '0;
        green_nxt = '0;
        blue_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

endmodule
